### rtl/setq_pkg.sv
// shared types and constants of the sorted event timer queue
package setq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 48;
  localparam int DEADLINE_W  = 49;
  localparam int DELAY_W     = 32;
  localparam int WAIT_W      = 31;
  localparam int REM_W       = 50;
  localparam int STEP_W      = 5;
  localparam int US_PER_MS   = 1000;

  // operation codes
  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_FIND     = 2'd2;
  localparam logic [1:0] OP_CHECK    = 2'd3;

  // cell commands
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;
  localparam logic [1:0] CELL_POP  = 2'd3;

  typedef struct packed {
    logic [1:0]          operation;
    logic [TIME_W-1:0]   now_us;
    logic [DELAY_W-1:0]  delay_us;
    logic [ID_WIDTH-1:0] handler_id;
    logic [ID_WIDTH-1:0] argument_id;
    logic                has_argument;
    logic                heavy;
  } in_t;

  typedef struct packed {
    logic                kind;
    logic [ID_WIDTH-1:0] fired_handler;
    logic [ID_WIDTH-1:0] fired_argument;
    logic                found;
    logic                queue_idle;
    logic [WAIT_W-1:0]   wait_ms;
    logic                queue_full;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [DEADLINE_W-1:0] deadline;
    logic [ID_WIDTH-1:0]   handler;
    logic [ID_WIDTH-1:0]   argument;
    logic                  heavy;
  } entry_t;

  typedef struct packed {
    logic [1:0]          mode;
    entry_t              new_entry;
    logic [ID_WIDTH-1:0] key_handler;
    logic [ID_WIDTH-1:0] key_argument;
    logic                wild;
  } cell_ctl_t;

endpackage

### rtl/setq_cell.sv
// one queue slot: holds an entry, shifts with its neighbours on insert and removal
module setq_cell (
  input  logic               clk,
  input  setq_pkg::cell_ctl_t ctl,
  input  setq_pkg::entry_t   prev_entry,
  input  setq_pkg::entry_t   next_entry,
  input  logic               occ,
  input  logic               later_in,
  input  logic               seen_in,
  output setq_pkg::entry_t   entry,
  output logic               later_out,
  output logic               seen_out
);
  import setq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   match;

  assign entry = entry_r;

  // new deadline goes before this slot, or slot is free
  assign later_out = !occ || (ctl.new_entry.deadline < entry_r.deadline);

  // key compare, wildcard argument on cancel with null argument
  assign match = occ && (entry_r.handler == ctl.key_handler) &&
                 (ctl.wild || (entry_r.argument == ctl.key_argument));
  assign seen_out = seen_in || match;

  // slot update
  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.mode)
      CELL_INS: begin
        if (later_in) entry_nxt = prev_entry;
        else if (later_out) entry_nxt = ctl.new_entry;
      end
      CELL_DEL: begin
        if (seen_out) entry_nxt = next_entry;
      end
      CELL_POP: begin
        if (seen_in) entry_nxt = next_entry;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### rtl/setq_wait_div.sv
// wait in milliseconds: saturating division by 1000 as a reciprocal product over the two halves of the dividend
module setq_wait_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [setq_pkg::REM_W-1:0]    dividend,
  output logic                          busy,
  output logic [setq_pkg::WAIT_W-1:0]   quotient
);
  import setq_pkg::*;

  // x / 1000 = (x >> 3) / 125, exact for x below the saturation limit
  localparam int Y_W     = 38;
  localparam int HALF_W  = 19;
  localparam int RECIP_W = 39;
  localparam int PROD_W  = 58;
  localparam int SUM_W   = 77;
  localparam int SHIFT   = 45;

  localparam logic [REM_W-1:0]   SAT_LIMIT = REM_W'(US_PER_MS) << WAIT_W;
  localparam logic [RECIP_W-1:0] RECIP     = 39'd281474976711;

  logic [Y_W-1:0]    y_r, y_nxt;
  logic [PROD_W-1:0] lo_r, lo_nxt;
  logic [PROD_W-1:0] hi_r, hi_nxt;
  logic [WAIT_W-1:0] q_r, q_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [HALF_W-1:0] mul_in;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum;

  assign busy     = (cnt_r != '0);
  assign quotient = q_r;

  // one half of the scaled dividend per cycle through a single multiplier
  assign mul_in = (cnt_r == STEP_W'(3)) ? y_r[HALF_W-1:0] : y_r[Y_W-1:HALF_W];
  assign prod   = PROD_W'(mul_in) * PROD_W'(RECIP);
  assign sum    = {hi_r, {HALF_W{1'b0}}} + SUM_W'(lo_r);

  // start saturates or loads the scaled dividend; then low product, high product, then combine and shift
  always_comb begin
    y_nxt   = y_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (start) begin
      if (dividend >= SAT_LIMIT) begin
        q_nxt   = '1;
        cnt_nxt = '0;
      end else begin
        y_nxt   = dividend[Y_W+2:3];
        cnt_nxt = STEP_W'(3);
      end
    end else if (busy) begin
      cnt_nxt = cnt_r - STEP_W'(1);
      unique case (cnt_r)
        STEP_W'(3): lo_nxt = prod;
        STEP_W'(2): hi_nxt = prod;
        default:    q_nxt  = sum[SHIFT+WAIT_W-1:SHIFT];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    y_r  <= y_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    q_r  <= q_nxt;
  end

endmodule

### rtl/sorted_event_timer_queue_unit.sv
// sorted timer event queue: row of slot cells, sequencer and wait divider
//
//  channel | ports                       | transfer
//  in      | in_valid in_ready in_data   | one request (schedule, cancel, find, check)
//  out     | out_valid out_ready out_data| fired entries then one final status
//
//  an item is latched in the idle state; schedule, find and cancel with an argument finish in
//  the execute state, cancel with a null argument removes matching entries one at a time, then
//  gives its status; check pops due entries one at a time, stopping after a heavy one, and runs
//  the wait division when the queue holds a head that is not due (cut short when the wait
//  saturates); each produced result waits while the output register is occupied
//  synchronous active-low reset empties the queue; slot contents are not cleared
module sorted_event_timer_queue_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  setq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output setq_pkg::out_t out_data
);
  import setq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  in_t              req_r;
  logic             stop_r, stop_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  cell_ctl_t  ctl;
  logic [1:0] cell_mode;
  entry_t     ents [QUEUE_DEPTH];
  logic       later [QUEUE_DEPTH];
  logic       seen  [QUEUE_DEPTH];
  logic       seen0;
  logic       any_match;

  logic                  out_free;
  logic                  head_due;
  logic [DEADLINE_W-1:0] now_ext;
  logic [DEADLINE_W-1:0] new_deadline;
  logic                  div_start;
  logic [REM_W-1:0]      div_x;
  logic                  div_busy;
  logic [WAIT_W-1:0]     div_q;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign now_ext      = {1'b0, req_r.now_us};
  assign new_deadline = (req_r.delay_us != '0) ?
                        (now_ext + DEADLINE_W'(req_r.delay_us)) : '0;
  assign head_due     = (count_r != '0) && (ents[0].deadline <= now_ext);
  assign div_x        = REM_W'(ents[0].deadline - now_ext) + REM_W'(US_PER_MS - 1);

  // key and new entry broadcast to the cells
  always_comb begin
    ctl.mode               = cell_mode;
    ctl.new_entry.deadline = new_deadline;
    ctl.new_entry.handler  = req_r.handler_id;
    ctl.new_entry.argument = req_r.has_argument ? req_r.argument_id : '0;
    ctl.new_entry.heavy    = req_r.heavy;
    ctl.key_handler        = req_r.handler_id;
    ctl.key_argument       = req_r.argument_id;
    ctl.wild               = (req_r.operation == OP_CANCEL) && (req_r.argument_id == '0);
  end

  // on check every slot shifts towards the head when popping
  assign seen0     = (req_r.operation == OP_CHECK);
  assign any_match = seen[QUEUE_DEPTH-1];

  // row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    setq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .prev_entry ((i == 0) ? ents[0] : ents[(i == 0) ? 0 : i-1]),
      .next_entry ((i == QUEUE_DEPTH-1) ? ents[i] : ents[(i == QUEUE_DEPTH-1) ? i : i+1]),
      .occ        (CNT_W'(i) < count_r),
      .later_in   ((i == 0) ? 1'b0 : later[(i == 0) ? 0 : i-1]),
      .seen_in    ((i == 0) ? seen0 : seen[(i == 0) ? 0 : i-1]),
      .entry      (ents[i]),
      .later_out  (later[i]),
      .seen_out   (seen[i])
    );
  end

  setq_wait_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_x),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    stop_nxt      = stop_r;
    count_nxt     = count_r;
    cell_mode     = CELL_HOLD;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          stop_nxt  = 1'b0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_data_nxt      = '0;
          out_data_nxt.kind = 1'b1;
          out_data_nxt.last = 1'b1;
          unique case (req_r.operation)
            OP_SCHEDULE: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                out_data_nxt.queue_full = 1'b1;
              end else begin
                cell_mode = CELL_INS;
                count_nxt = count_r + CNT_W'(1);
              end
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
            OP_CANCEL: begin
              if (any_match) begin
                cell_mode = CELL_DEL;
                count_nxt = count_r - CNT_W'(1);
              end
              if (!any_match || !ctl.wild) begin
                out_valid_nxt = 1'b1;
                state_nxt     = ST_IDLE;
              end
            end
            OP_FIND: begin
              out_data_nxt.found = any_match;
              out_valid_nxt      = 1'b1;
              state_nxt          = ST_IDLE;
            end
            default: begin
              if (head_due && !stop_r) begin
                out_data_nxt.kind           = 1'b0;
                out_data_nxt.last           = 1'b0;
                out_data_nxt.fired_handler  = ents[0].handler;
                out_data_nxt.fired_argument = ents[0].argument;
                out_valid_nxt               = 1'b1;
                cell_mode                   = CELL_POP;
                count_nxt                   = count_r - CNT_W'(1);
                if (ents[0].heavy) stop_nxt = 1'b1;
              end else if (count_r == '0) begin
                out_data_nxt.queue_idle = 1'b1;
                out_valid_nxt           = 1'b1;
                state_nxt               = ST_IDLE;
              end else if (head_due) begin
                out_valid_nxt = 1'b1;
                state_nxt     = ST_IDLE;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
          endcase
        end
      end
      default: begin
        if (!div_busy && out_free) begin
          out_data_nxt         = '0;
          out_data_nxt.kind    = 1'b1;
          out_data_nxt.last    = 1'b1;
          out_data_nxt.wait_ms = div_q;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stop_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stop_r      <= stop_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_valid && in_ready) req_r <= in_data;
    out_data_r <= out_data_nxt;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.mode == CELL_INS) |-> (count_r < CNT_W'(QUEUE_DEPTH)))
    else $error("insert into full queue");

  a_div_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> $stable(count_r))
    else $error("queue changed during wait division");

endmodule
